### rtl/sdss_pkg.sv
// Package for the signed decimal to seven-segment formatter.
// Holds widths, character codes and the segment table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sdss_pkg;
    localparam int MaxDigitsDefault = 8;
    localparam int ValueBitsDefault = 32;
    localparam int CodeW = 5;
    localparam int SegW = 7;
    localparam int CfgW = 4;
    localparam logic [CodeW-1:0] CODE_ZERO = 5'd1;
    localparam logic [CodeW-1:0] CODE_MINUS = 5'd11;
    localparam logic [CfgW-1:0] REG_DIGIT_COUNT = 4'd0;
    localparam logic [CfgW-1:0] REG_DOT_COUNT = 4'd1;

    function automatic logic [SegW-1:0] seg_of(input logic [CodeW-1:0] code);
        logic [SegW-1:0] s;
        case (code)
            5'd0: s = 7'h00;
            5'd1: s = 7'h3F;
            5'd2: s = 7'h06;
            5'd3: s = 7'h5B;
            5'd4: s = 7'h4F;
            5'd5: s = 7'h66;
            5'd6: s = 7'h6D;
            5'd7: s = 7'h7D;
            5'd8: s = 7'h07;
            5'd9: s = 7'h7F;
            5'd10: s = 7'h6F;
            5'd11: s = 7'h40;
            5'd12: s = 7'h77;
            5'd13: s = 7'h7C;
            5'd14: s = 7'h39;
            5'd15: s = 7'h5E;
            5'd16: s = 7'h79;
            5'd17: s = 7'h71;
            5'd18: s = 7'h76;
            5'd19: s = 7'h38;
            5'd20: s = 7'h54;
            5'd21: s = 7'h73;
            5'd22: s = 7'h50;
            5'd23: s = 7'h78;
            5'd24: s = 7'h3E;
            5'd25: s = 7'h1E;
            5'd26: s = 7'h6E;
            5'd27: s = 7'h5B;
            default: s = 7'h00;
        endcase
        return s;
    endfunction
endpackage
`default_nettype wire

### rtl/sdss_dabble_stage.sv
// One register stage of the double-dabble binary to BCD conversion.
// Shifts STEP bits of the binary word into the BCD digits; uses sdss_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sdss_dabble_stage #(
    parameter int BinW = 32,
    parameter int BcdW = 40,
    parameter int Step = 4
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire logic                i_valid,
    input  wire logic [BinW-1:0]     i_bin,
    input  wire logic [BcdW-1:0]     i_bcd,
    input  wire logic                i_neg,
    input  wire logic [sdss_pkg::CodeW-1:0] i_fill,
    output logic                     o_valid,
    output logic [BinW-1:0]          o_bin,
    output logic [BcdW-1:0]          o_bcd,
    output logic                     o_neg,
    output logic [sdss_pkg::CodeW-1:0] o_fill
);
    import sdss_pkg::*;
    localparam int NDig = BcdW / 4;
    logic [BinW-1:0] n_bin;
    logic [BcdW-1:0] n_bcd;

    always_comb begin
        n_bin = i_bin;
        n_bcd = i_bcd;
        for (int s = 0; s < Step; s++) begin
            for (int d = 0; d < NDig; d++) begin
                if (n_bcd[d*4 +: 4] > 4'd4) begin
                    n_bcd[d*4 +: 4] = n_bcd[d*4 +: 4] + 4'd3;
                end
            end
            n_bcd = {n_bcd[BcdW-2:0], n_bin[BinW-1]};
            n_bin = {n_bin[BinW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
        if (i_en) begin
            o_bin  <= n_bin;
            o_bcd  <= n_bcd;
            o_neg  <= i_neg;
            o_fill <= i_fill;
        end
    end
endmodule
`default_nettype wire

### rtl/signed_decimal_to_seven_segment.sv
// Signed decimal to seven-segment formatter, top level.
// A request passes stage 0, the dabble stages and the emitter register before its first position.
// One position per cycle unless i_stall; digit_count positions (1..MaxDigits) per request.
// The conversion pipeline takes a request every cycle unless o_stall; the emitter holds it.
// Synchronous active-low reset: digit_count 4, dot_count 0, pipeline empty.
`timescale 1ns / 1ps
`default_nettype none
module signed_decimal_to_seven_segment #(
    parameter int MaxDigits = sdss_pkg::MaxDigitsDefault,
    parameter int ValueBits = sdss_pkg::ValueBitsDefault
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [sdss_pkg::CfgW-1:0] i_cfg_index,
    input  wire logic [sdss_pkg::CfgW-1:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_signed_value,
    input  wire logic [4:0]  i_fill_code,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_position,
    output logic [4:0]       o_char_code,
    output logic [6:0]       o_segments,
    output logic             o_dot_on,
    output logic             o_last
);
    import sdss_pkg::*;
    localparam int Step = 4;
    localparam int NStage = (ValueBits + Step - 1) / Step;
    localparam int BinW = NStage * Step;
    localparam int NBcd = 10;
    localparam int BcdW = NBcd * 4;

    logic [CfgW-1:0] r_digit_count, r_dot_count;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_count <= 4'd4;
            r_dot_count   <= 4'd0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_DIGIT_COUNT) r_digit_count <= i_cfg_data;
            if (i_cfg_index == REG_DOT_COUNT)   r_dot_count <= i_cfg_data;
        end
    end

    // Pipeline advance: the final stage feeds the emitter register.
    logic w_adv;

    // Stage 0: magnitude.
    logic                 r_v0, r_neg0;
    logic [BinW-1:0]      r_mag0;
    logic [CodeW-1:0]     r_fill0;
    logic [ValueBits-1:0] w_raw, w_mag;
    assign w_raw = i_signed_value[ValueBits-1:0];
    assign w_mag = w_raw[ValueBits-1] ? (~w_raw + 1'b1) : w_raw;
    assign o_stall = !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_adv) begin
            r_v0 <= i_valid;
        end
        if (w_adv) begin
            r_neg0  <= w_raw[ValueBits-1];
            r_mag0  <= BinW'({1'b0, w_mag}) << (BinW - ValueBits);
            r_fill0 <= i_fill_code;
        end
    end

    logic                 w_v   [NStage+1];
    logic [BinW-1:0]      w_bin [NStage+1];
    logic [BcdW-1:0]      w_bcd [NStage+1];
    logic                 w_neg [NStage+1];
    logic [CodeW-1:0]     w_fill[NStage+1];
    assign w_v[0] = r_v0;
    assign w_bin[0] = r_mag0;
    assign w_bcd[0] = '0;
    assign w_neg[0] = r_neg0;
    assign w_fill[0] = r_fill0;

    for (genvar g = 0; g < NStage; g++) begin : g_stage
        sdss_dabble_stage #(.BinW(BinW), .BcdW(BcdW), .Step(Step)) u_stage (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_adv),
            .i_valid(w_v[g]), .i_bin(w_bin[g]), .i_bcd(w_bcd[g]),
            .i_neg(w_neg[g]), .i_fill(w_fill[g]),
            .o_valid(w_v[g+1]), .o_bin(w_bin[g+1]), .o_bcd(w_bcd[g+1]),
            .o_neg(w_neg[g+1]), .o_fill(w_fill[g+1])
        );
    end

    // Digit count of the last stage's value: highest nonzero BCD digit.
    logic [3:0] w_ndig;
    always_comb begin
        w_ndig = 4'd1;
        for (int d = 0; d < NBcd; d++) begin
            if (w_bcd[NStage][d*4 +: 4] != 4'd0) w_ndig = 4'(d + 1);
        end
    end

    // Emitter: holds one converted request and walks its positions.
    logic             r_busy;
    logic [BcdW-1:0]  r_bcd;
    logic [3:0]       r_ndig;
    logic             r_neg;
    logic [CodeW-1:0] r_fill;
    logic [2:0]       r_pos;
    logic [3:0]       w_n;
    logic             w_take, w_done;

    assign w_n = (r_digit_count == 4'd0) ? 4'd1 :
                 (r_digit_count > 4'(MaxDigits)) ? 4'(MaxDigits) : r_digit_count;
    assign w_done = r_busy && !i_stall && ({1'b0, r_pos} == w_n - 4'd1);
    assign w_adv = !w_v[NStage] || !r_busy || w_done;
    assign w_take = w_adv && w_v[NStage];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= 3'd0;
        end else if (w_take) begin
            r_busy <= 1'b1;
            r_pos  <= 3'd0;
        end else if (w_done) begin
            r_busy <= 1'b0;
            r_pos  <= 3'd0;
        end else if (r_busy && !i_stall) begin
            r_pos <= r_pos + 3'd1;
        end
        if (w_take) begin
            r_bcd  <= w_bcd[NStage];
            r_ndig <= w_ndig;
            r_neg  <= w_neg[NStage];
            r_fill <= w_fill[NStage];
        end
    end

    // Position p shows digit k = n-1-p from the right.
    logic [3:0]       w_k, w_used;
    logic [CodeW-1:0] w_code;
    logic [3:0]       w_dig;
    always_comb begin
        w_k = w_n - 4'd1 - {1'b0, r_pos};
        w_used = (r_ndig < w_n) ? r_ndig : w_n;
        w_dig = r_bcd[w_k*4 +: 4];
        if (w_k < w_used) begin
            w_code = CODE_ZERO + {1'b0, w_dig};
        end else if (r_neg && w_k == r_ndig) begin
            w_code = CODE_MINUS;
        end else begin
            w_code = r_fill;
        end
    end

    assign o_valid     = r_busy;
    assign o_position  = r_pos;
    assign o_char_code = w_code;
    assign o_segments  = seg_of(w_code);
    assign o_dot_on    = ({1'b0, r_pos} < r_dot_count);
    assign o_last      = ({1'b0, r_pos} == w_n - 4'd1);
endmodule
`default_nettype wire
